/* src/sample_kurtosis_unit_defines.svh */
// ----------------------------------------------------------------------------
// Sample kurtosis unit assertion macros
// Shared property forms for the checks in the top level.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_KURTOSIS_UNIT_DEFINES_SVH
`define SAMPLE_KURTOSIS_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define SK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sample kurtosis check failed");

// next-cycle implication, held off during reset
`define SK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sample kurtosis check failed");

`endif

/* src/sk_pkg.sv */
// ----------------------------------------------------------------------------
// Sample kurtosis package
// Widths, codes and the per-set summary passed from front to back.
// ----------------------------------------------------------------------------
package sk_pkg;
    localparam int MAX_SAMPLES = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_W    = 12;
    localparam int DEV_W       = SAMPLE_W + 1;
    localparam int SQ_W        = 2 * DEV_W - 2;
    localparam int QD_W        = 2 * SQ_W;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int S2_W        = 37;
    localparam int S4_W        = 61;
    localparam int WIDE_W      = 128;
    localparam int MUL_W       = S2_W;
    localparam int BIT_W       = $clog2(WIDE_W);
    localparam int VALUE_W     = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int LVL_W       = FIFO_AW + 1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_FLAT = 2'd2;
    localparam logic [1:0] ST_MANY = 2'd3;

    localparam logic CFG_CENTER = 1'b0;
    localparam logic CFG_PLAIN  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [S2_W-1:0]  s2;
        logic [S4_W-1:0]  s4;
        logic             ovf;
        logic             plain;
    } t_set_sum;
endpackage

/* src/sk_in_if.sv */
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying one sample and its end-of-set mark.
// ----------------------------------------------------------------------------
interface sk_in_if import sk_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

/* src/sk_out_if.sv */
// ----------------------------------------------------------------------------
// Kurtosis result channel
// Valid/ready channel carrying one kurtosis value and its status.
// ----------------------------------------------------------------------------
interface sk_out_if import sk_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] kurtosis_value;
    logic [1:0]                status;

    modport source (output valid, output kurtosis_value, output status, input ready);
    modport sink   (input valid, input kurtosis_value, input status, output ready);
endinterface

/* src/sk_front.sv */
// ----------------------------------------------------------------------------
// Sample kurtosis front end
// Accepts samples, forms d^2 and d^4 in a pipeline, accumulates the moments
// and pushes one summary per set into the queue.
// ----------------------------------------------------------------------------
module sk_front import sk_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    input  logic signed [SAMPLE_W-1:0] i_center,
    input  logic                       i_plain,
    input  logic [LVL_W-1:0]           i_fifo_level,
    output logic                       o_push,
    output t_set_sum                   o_push_data
);
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             counted;
        logic [CNT_W-1:0] count;
        logic             ovf;
        logic             plain;
    } t_meta;

    t_meta                   r_s1, r_s2, r_s3, n_s1;
    logic signed [DEV_W-1:0] r_dev;
    logic [SQ_W-1:0]         r_s2_sq, r_s3_sq;
    logic [QD_W-1:0]         r_s3_qd;
    logic [CNT_W-1:0]        r_cnt, cnt_inc;
    logic                    r_ovf;
    logic [S2_W-1:0]         r_acc_s2, sum_s2;
    logic [S4_W-1:0]         r_acc_s4, sum_s4;
    logic                    accept, counted;
    logic [LVL_W-1:0]        pending;
    logic [2*DEV_W-1:0]      sq_full;

    // reserve queue room for every set end still in flight
    assign pending = i_fifo_level + LVL_W'(r_s1.valid & r_s1.last)
                   + LVL_W'(r_s2.valid & r_s2.last) + LVL_W'(r_s3.valid & r_s3.last);
    assign o_ready = pending < LVL_W'(FIFO_DEPTH);
    assign accept  = i_valid & o_ready;
    assign counted = r_cnt < CNT_W'(MAX_SAMPLES);
    assign cnt_inc = r_cnt + CNT_W'(counted);
    assign sq_full = (2*DEV_W)'(r_dev * r_dev);

    always_comb begin
        n_s1.valid   = accept;
        n_s1.last    = i_last;
        n_s1.counted = counted;
        n_s1.count   = cnt_inc;
        n_s1.ovf     = r_ovf | ~counted;
        n_s1.plain   = i_plain;
    end

    assign sum_s2 = r_acc_s2 + (r_s3.counted ? S2_W'(r_s3_sq) : '0);
    assign sum_s4 = r_acc_s4 + (r_s3.counted ? S4_W'(r_s3_qd) : '0);

    assign o_push            = r_s3.valid & r_s3.last;
    assign o_push_data.count = r_s3.count;
    assign o_push_data.s2    = sum_s2;
    assign o_push_data.s4    = sum_s4;
    assign o_push_data.ovf   = r_s3.ovf;
    assign o_push_data.plain = r_s3.plain;

    always_ff @(posedge i_clk) begin
        r_dev   <= DEV_W'(i_sample) - DEV_W'(i_center);
        r_s2_sq <= sq_full[SQ_W-1:0];
        r_s3_sq <= r_s2_sq;
        r_s3_qd <= r_s2_sq * r_s2_sq;
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_s2     <= '0;
            r_s3     <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_acc_s2 <= '0;
            r_acc_s4 <= '0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            if (accept) begin
                if (i_last) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_cnt <= cnt_inc;
                    r_ovf <= n_s1.ovf;
                end
            end
            if (r_s3.valid) begin
                if (r_s3.last) begin
                    r_acc_s2 <= '0;
                    r_acc_s4 <= '0;
                end else begin
                    r_acc_s2 <= sum_s2;
                    r_acc_s4 <= sum_s4;
                end
            end
        end
    end
endmodule

/* src/sk_fifo.sv */
// ----------------------------------------------------------------------------
// Set summary queue
// Small FIFO between the accumulating front end and the ratio back end.
// ----------------------------------------------------------------------------
module sk_fifo import sk_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_set_sum         i_data,
    input  logic             i_pop,
    output t_set_sum         o_data,
    output logic             o_empty,
    output logic [LVL_W-1:0] o_level
);
    t_set_sum           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [LVL_W-1:0]   r_level;

    assign o_data  = r_mem[r_rd];
    assign o_empty = r_level == '0;
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_level <= r_level + LVL_W'(i_push) - LVL_W'(i_pop);
        end
    end
endmodule

/* src/sk_back.sv */
// ----------------------------------------------------------------------------
// Sample kurtosis back end
// Forms the numerator and denominator with a shift-add multiplier, divides
// one bit per cycle, rounds, saturates and holds the result for the sink.
// ----------------------------------------------------------------------------
module sk_back import sk_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  t_set_sum                  i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [1:0]                o_status
);
    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_SUB, S_BIAS, S_DIV, S_SAT, S_DONE} t_state;

    // multiply program
    localparam logic [3:0] K_SQ = 4'd0;  // sq = S2*S2
    localparam logic [3:0] K_PN = 4'd1;  // p = S4*n (plain)
    localparam logic [3:0] K_D1 = 4'd2;  // den = sq*(n-2)
    localparam logic [3:0] K_D2 = 4'd3;  // den *= n-3
    localparam logic [3:0] K_Q1 = 4'd4;  // q = 3*sq
    localparam logic [3:0] K_Q2 = 4'd5;  // q *= n-1
    localparam logic [3:0] K_Q3 = 4'd6;  // q *= n-1
    localparam logic [3:0] K_P1 = 4'd7;  // p = 3*den
    localparam logic [3:0] K_T1 = 4'd8;  // t = S4*(n-1)
    localparam logic [3:0] K_T2 = 4'd9;  // t *= n+1
    localparam logic [3:0] K_T3 = 4'd10; // p += t*n

    t_state              r_state;
    t_set_sum            r_job;
    logic [3:0]          r_step;
    logic [WIDE_W-1:0]   r_sq, r_den, r_q, r_p, r_t, r_mx, r_acc, r_num, r_rem, r_quo;
    logic [MUL_W-1:0]    r_mm;
    logic [BIT_W-1:0]    r_bit;
    logic                r_neg;
    logic [1:0]          r_status;
    logic [VALUE_W-1:0]  r_value;
    logic                r_out_v;
    logic [VALUE_W-1:0]  r_out_val;
    logic [1:0]          r_out_st;

    logic [CNT_W-1:0]    n_m1, n_m2, n_m3, n_p1;
    logic [1:0]          head_status;
    logic [WIDE_W:0]     rem_sh;
    logic                ge;
    logic                p_lt_q;
    logic                out_free;
    logic                quo_hi;

    assign n_m1 = r_job.count - CNT_W'(1);
    assign n_m2 = r_job.count - CNT_W'(2);
    assign n_m3 = r_job.count - CNT_W'(3);
    assign n_p1 = r_job.count + CNT_W'(1);

    always_comb begin
        if (i_head.ovf) begin
            head_status = ST_MANY;
        end else if (!i_head.plain && i_head.count <= CNT_W'(3)) begin
            head_status = ST_FEW;
        end else if (i_head.s2 == '0) begin
            head_status = ST_FLAT;
        end else begin
            head_status = ST_OK;
        end
    end

    assign rem_sh   = {r_rem, r_num[WIDE_W-1]};
    assign ge       = rem_sh >= {1'b0, r_den};
    assign p_lt_q   = r_p < r_q;
    assign out_free = !r_out_v || i_ready;
    assign quo_hi   = r_quo[WIDE_W-1:VALUE_W] != '0;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    assign o_valid  = r_out_v;
    assign o_value  = r_out_val;
    assign o_status = r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            // drop the taken transaction unless a new one replaces it
            if (r_out_v && i_ready && r_state != S_DONE) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job    <= i_head;
                        r_status <= head_status;
                        r_value  <= '0;
                        r_step   <= K_SQ;
                        r_state  <= (head_status == ST_OK) ? S_LOAD : S_DONE;
                    end
                end
                S_LOAD: begin
                    r_acc <= (r_step == K_T3) ? r_p : '0;
                    case (r_step)
                        K_SQ: begin
                            r_mx <= WIDE_W'(r_job.s2);
                            r_mm <= r_job.s2;
                        end
                        K_PN: begin
                            r_mx <= WIDE_W'(r_job.s4);
                            r_mm <= MUL_W'(r_job.count);
                        end
                        K_D1: begin
                            r_mx <= r_sq;
                            r_mm <= MUL_W'(n_m2);
                        end
                        K_D2: begin
                            r_mx <= r_den;
                            r_mm <= MUL_W'(n_m3);
                        end
                        K_Q1: begin
                            r_mx <= r_sq;
                            r_mm <= MUL_W'(3);
                        end
                        K_Q2, K_Q3: begin
                            r_mx <= r_q;
                            r_mm <= MUL_W'(n_m1);
                        end
                        K_P1: begin
                            r_mx <= r_den;
                            r_mm <= MUL_W'(3);
                        end
                        K_T1: begin
                            r_mx <= WIDE_W'(r_job.s4);
                            r_mm <= MUL_W'(n_m1);
                        end
                        K_T2: begin
                            r_mx <= r_t;
                            r_mm <= MUL_W'(n_p1);
                        end
                        K_T3: begin
                            r_mx <= r_t;
                            r_mm <= MUL_W'(r_job.count);
                        end
                        default: begin
                            r_mx <= '0;
                            r_mm <= '0;
                        end
                    endcase
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mm != '0) begin
                        if (r_mm[0]) begin
                            r_acc <= r_acc + r_mx;
                        end
                        r_mx <= r_mx << 1;
                        r_mm <= r_mm >> 1;
                    end else begin
                        case (r_step)
                            K_SQ: begin
                                r_sq    <= r_acc;
                                r_step  <= r_job.plain ? K_PN : K_D1;
                                r_state <= S_LOAD;
                            end
                            K_PN: begin
                                r_p     <= r_acc;
                                r_den   <= r_sq;
                                r_q     <= '0;
                                r_state <= S_SUB;
                            end
                            K_D1, K_D2: begin
                                r_den   <= r_acc;
                                r_step  <= r_step + 4'd1;
                                r_state <= S_LOAD;
                            end
                            K_Q1, K_Q2, K_Q3: begin
                                r_q     <= r_acc;
                                r_step  <= r_step + 4'd1;
                                r_state <= S_LOAD;
                            end
                            K_P1: begin
                                r_p     <= r_acc;
                                r_step  <= r_step + 4'd1;
                                r_state <= S_LOAD;
                            end
                            K_T1, K_T2: begin
                                r_t     <= r_acc;
                                r_step  <= r_step + 4'd1;
                                r_state <= S_LOAD;
                            end
                            K_T3: begin
                                r_p     <= r_acc;
                                r_state <= S_SUB;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SUB: begin
                    r_neg   <= p_lt_q;
                    r_num   <= (p_lt_q ? (r_q - r_p) : (r_p - r_q)) << FRAC_BITS;
                    r_state <= S_BIAS;
                end
                S_BIAS: begin
                    // round half away from zero on the magnitude
                    r_num   <= r_num + (r_den >> 1);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_bit   <= BIT_W'(WIDE_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= ge ? WIDE_W'(rem_sh - {1'b0, r_den}) : rem_sh[WIDE_W-1:0];
                    r_quo   <= {r_quo[WIDE_W-2:0], ge};
                    r_num   <= r_num << 1;
                    r_bit   <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (r_neg) begin
                        if (quo_hi || r_quo[VALUE_W-1:0] > {1'b1, {(VALUE_W-1){1'b0}}}) begin
                            r_value <= {1'b1, {(VALUE_W-1){1'b0}}};
                        end else begin
                            r_value <= '0 - r_quo[VALUE_W-1:0];
                        end
                    end else if (quo_hi || r_quo[VALUE_W-1]) begin
                        r_value <= {1'b0, {(VALUE_W-1){1'b1}}};
                    end else begin
                        r_value <= r_quo[VALUE_W-1:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_v   <= 1'b1;
                        r_out_val <= r_value;
                        r_out_st  <= r_status;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* src/sample_kurtosis_unit.sv */
// ----------------------------------------------------------------------------
// Sample kurtosis unit
// Streams signed samples and returns the kurtosis of each marked set.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle: a three-stage pipeline forms d = sample -
// center, d^2 and d^4 and accumulates count and sums. When a set's last
// sample leaves the pipeline its sums go into a four-entry queue, so the
// next set streams in while earlier sets are finished. The finishing engine
// runs a shift-add multiplier (one bit of the multiplier per cycle, plus a
// load and a store step per product) and a 128-bit restoring divider; a set
// in plain mode needs fewer products than one in corrected mode, and an
// error status skips the arithmetic. Input stalls only when four set ends
// are queued or in flight.
`include "sample_kurtosis_unit_defines.svh"

module sample_kurtosis_unit import sk_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sk_in_if.sink               i_in,
    sk_out_if.source            o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [SAMPLE_W-1:0] i_cfg_data
);
    logic signed [SAMPLE_W-1:0] r_center;
    logic                       r_plain;
    logic                       push, pop, empty;
    t_set_sum                   push_data, head;
    logic [LVL_W-1:0]           level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_plain  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER: r_center <= i_cfg_data;
                CFG_PLAIN:  r_plain  <= i_cfg_data[0];
                default:    r_plain  <= r_plain;
            endcase
        end
    end

    sk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_sample     (i_in.sample),
        .i_last       (i_in.last_sample),
        .i_center     (r_center),
        .i_plain      (r_plain),
        .i_fifo_level (level),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    sk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head),
        .o_empty (empty),
        .o_level (level)
    );

    sk_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_value  (o_out.kurtosis_value),
        .o_status (o_out.status)
    );

    `SK_ASSERT_NOW(a_no_overfill, i_clk, i_rst_n, push, level != LVL_W'(FIFO_DEPTH))
    `SK_ASSERT_NOW(a_no_underrun, i_clk, i_rst_n, pop, !empty)
    `SK_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_out.valid && o_out.status != ST_OK, o_out.kurtosis_value == '0)
    `SK_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, push && !pop, level != '0)
endmodule
